@@ rtl/core/stcl_pkg.sv @@
`default_nettype none

package stcl_pkg;

	localparam int FRAC       = 30;
	localparam int LIN_W      = 31;  // linear component, 1.30
	localparam int RAT_W      = 31;  // white-relative xyz, 1.30
	localparam int F_W        = 31;  // f(t), 1.30
	localparam int CODE_W     = 16;
	localparam int CBRT_STEPS = F_W;
	localparam int XYZ_NUM_W  = 48;
	localparam int LIN_NUM_W  = 52;
	localparam int L_NUM_W    = 26;
	localparam int L_QW       = 17;
	localparam int CDIV_LAT   = 3;   // constant divider stages

	localparam int XYZ_LAT  = 3 + CDIV_LAT;
	localparam int FLAB_LAT = 2 * CBRT_STEPS + 1;
	localparam int LAB_LAT  = CDIV_LAT + 4;
	localparam int PIPE_LAT = XYZ_LAT + FLAB_LAT + LAB_LAT;

	typedef logic [LIN_W-1:0]  lin_t;
	typedef logic [RAT_W-1:0]  ratio_t;
	typedef logic [F_W-1:0]    f_t;
	typedef logic [CODE_W-1:0] code_t;
	typedef lin_t lin_tab_t [256];

	localparam longint unsigned ONE_C  = 64'd1 << FRAC;
	localparam longint unsigned HALF_C = 64'd1 << (FRAC - 1);

	function automatic longint unsigned fmul(longint unsigned a, longint unsigned b);
		return (a * b + HALF_C) >> FRAC;
	endfunction

	function automatic longint unsigned pow5(longint unsigned v);
		longint unsigned v2;
		v2 = fmul(v, v);
		return fmul(fmul(v2, v2), v);
	endfunction

	// gamma linearisation of one 8-bit code
	function automatic lin_t lin_val(int unsigned c);
		longint unsigned cc, u, u2, lo, hi, mid;
		cc = 64'(c);
		if (c < 11) begin
			return lin_t'((cc * 10 * ONE_C + 16473) / 32946);
		end
		u  = ((1000 * cc + 14025) * ONE_C + 134512) / 269025;
		u2 = fmul(u, u);
		lo = 0;
		hi = ONE_C;
		while (lo < hi) begin
			mid = lo + (hi - lo + 1) / 2;
			if (pow5(mid) <= u2) begin
				lo = mid;
			end else begin
				hi = mid - 1;
			end
		end
		return lin_t'(fmul(u2, lo));
	endfunction

	function automatic lin_tab_t lin_table();
		lin_tab_t tab;
		for (int i = 0; i < 256; i++) begin
			tab[i] = lin_val(i);
		end
		return tab;
	endfunction

endpackage

`default_nettype wire

@@ rtl/core/stcl_cdiv.sv @@
`default_nettype none

module stcl_cdiv #(
	parameter int NUM_W   = 48,
	parameter int QUO_W   = 31,
	parameter int Divisor = 95047
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	output logic [QUO_W-1:0] quo
);
	// floor division by a constant as a multiply by the rounded-up reciprocal
	// three stages: partial products, row sums, final sum and shift
	localparam int SH   = NUM_W + $clog2(Divisor);
	localparam int M_W  = NUM_W + 2;
	localparam int NL   = (NUM_W + 15) / 16;
	localparam int ML   = (M_W + 23) / 24;
	localparam int NX_W = NL * 16;
	localparam int PP_W = 40;
	localparam int W    = NX_W + ML * 24;
	localparam logic [W-1:0] M_C = ((W'(1) << SH) + W'(Divisor - 1)) / W'(Divisor);

	logic [NX_W-1:0] num_x;
	logic [PP_W-1:0] pp_s1  [NL][ML];
	logic [W-1:0]    row_c  [NL];
	logic [W-1:0]    row_s2 [NL];
	logic [W-1:0]    total;

	assign num_x = NX_W'(num);

	// 16 by 24 bit partial products
	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++) begin
				for (int j = 0; j < ML; j++) begin
					pp_s1[k][j] <= PP_W'(num_x[16*k +: 16]) * PP_W'(M_C[24*j +: 24]);
				end
			end
		end
	end

	always_comb begin
		for (int k = 0; k < NL; k++) begin
			row_c[k] = '0;
			for (int j = 0; j < ML; j++) begin
				row_c[k] = row_c[k] + (W'(pp_s1[k][j]) << (24 * j));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NL; k++) begin
				row_s2[k] <= row_c[k];
			end
		end
	end

	always_comb begin
		total = '0;
		for (int k = 0; k < NL; k++) begin
			total = total + (row_s2[k] << (16 * k));
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			quo <= QUO_W'(total >> SH);
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/stcl_cbrt.sv @@
`default_nettype none

module stcl_cbrt (
	input  logic            clk,
	input  logic            en,
	input  stcl_pkg::ratio_t t,
	output stcl_pkg::f_t     root
);
	import stcl_pkg::*;

	// largest root below 1.5 whose rounded cube stays at or below t
	localparam logic [F_W-1:0] ROOT_MAX = F_W'(3 * HALF_C - 1);

	logic [F_W-1:0]   cand_s [CBRT_STEPS];
	logic [31:0]      sq_s   [CBRT_STEPS];
	logic [F_W-1:0]   loa_s  [CBRT_STEPS];
	logic [RAT_W-1:0] ta_s   [CBRT_STEPS];
	logic [F_W-1:0]   lo_s   [CBRT_STEPS];
	logic [RAT_W-1:0] tb_s   [CBRT_STEPS-1];

	for (genvar i = 0; i < CBRT_STEPS; i++) begin : g_bit
		logic [F_W-1:0]   lo_in;
		logic [RAT_W-1:0] t_in;
		logic [F_W-1:0]   cand;
		logic [63:0]      p_sq;
		logic [63:0]      p_cu;
		logic [63:0]      cu;
		logic             keep;

		if (i == 0) begin : g_first
			assign lo_in = '0;
			assign t_in  = t;
		end else begin : g_next
			assign lo_in = lo_s[i-1];
			assign t_in  = tb_s[i-1];
		end

		// square of the trial value
		assign cand = lo_in | (F_W'(1) << (F_W - 1 - i));
		assign p_sq = 64'(cand) * 64'(cand);

		always_ff @(posedge clk) begin
			if (en) begin
				cand_s[i] <= cand;
				sq_s[i]   <= 32'((p_sq + HALF_C) >> FRAC);
				loa_s[i]  <= lo_in;
				ta_s[i]   <= t_in;
			end
		end

		// cube and decision
		assign p_cu = 64'(sq_s[i]) * 64'(cand_s[i]);
		assign cu   = (p_cu + HALF_C) >> FRAC;
		assign keep = (cand_s[i] <= ROOT_MAX) && (cu <= 64'(ta_s[i]));

		always_ff @(posedge clk) begin
			if (en) begin
				lo_s[i] <= keep ? cand_s[i] : loa_s[i];
			end
		end

		if (i < CBRT_STEPS - 1) begin : g_t
			always_ff @(posedge clk) begin
				if (en) begin
					tb_s[i] <= ta_s[i];
				end
			end
		end
	end

	assign root = lo_s[CBRT_STEPS-1];

endmodule

`default_nettype wire

@@ rtl/core/stcl_flab.sv @@
`default_nettype none

module stcl_flab (
	input  logic             clk,
	input  logic             en,
	input  stcl_pkg::ratio_t t,
	output stcl_pkg::f_t     f
);
	import stcl_pkg::*;

	localparam logic [LIN_NUM_W-1:0] LIN_SLOPE  = LIN_NUM_W'(7787 * 116);
	localparam logic [LIN_NUM_W-1:0] LIN_OFFSET = LIN_NUM_W'(16000 * ONE_C + 58000);
	localparam logic [LIN_NUM_W-1:0] TEST_MUL   = LIN_NUM_W'(1000000);
	localparam logic [LIN_NUM_W-1:0] TEST_LIM   = LIN_NUM_W'(8856 * ONE_C);
	localparam int ROOT_LAT = 2 * CBRT_STEPS;
	localparam int LIN_PAD  = ROOT_LAT - (2 + CDIV_LAT);

	logic [LIN_NUM_W-1:0] lprod_s1;
	logic [LIN_NUM_W-1:0] lnum_s2;
	logic [F_W-1:0]       lin_q;
	logic [F_W-1:0]       root;
	logic [F_W-1:0]       lin_d  [LIN_PAD];
	logic                 tiny_d [ROOT_LAT];

	stcl_cbrt u_cbrt (
		.clk (clk),
		.en  (en),
		.t   (t),
		.root(root)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lprod_s1  <= LIN_NUM_W'(t) * LIN_SLOPE;
			lnum_s2   <= lprod_s1 + LIN_OFFSET;
		end
	end

	stcl_cdiv #(
		.NUM_W  (LIN_NUM_W),
		.QUO_W  (F_W),
		.Divisor(116000)
	) u_ldiv (
		.clk(clk),
		.en (en),
		.num(lnum_s2),
		.quo(lin_q)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			tiny_d[0] <= (LIN_NUM_W'(t) * TEST_MUL) <= TEST_LIM;
			lin_d[0] <= lin_q;
			for (int i = 1; i < LIN_PAD; i++) begin
				lin_d[i] <= lin_d[i-1];
			end
			for (int i = 1; i < ROOT_LAT; i++) begin
				tiny_d[i] <= tiny_d[i-1];
			end
			f <= tiny_d[ROOT_LAT-1] ? lin_d[LIN_PAD-1] : root;
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/stcl_lab.sv @@
`default_nettype none

module stcl_lab (
	input  logic          clk,
	input  logic          en,
	input  stcl_pkg::f_t  fx,
	input  stcl_pkg::f_t  fy,
	input  stcl_pkg::f_t  fz,
	output stcl_pkg::code_t lightness_code,
	output stcl_pkg::code_t a_code,
	output stcl_pkg::code_t b_code
);
	import stcl_pkg::*;

	localparam int S1_W = 42;
	localparam int S2_W = 56;
	localparam logic signed [S1_W-1:0] L_OFS  = S1_W'(16 * ONE_C);
	localparam logic signed [S1_W-1:0] AB_OFS = S1_W'(128 * ONE_C);
	localparam logic signed [S2_W-1:0] L_RND  = S2_W'(50 * ONE_C);
	localparam logic signed [S2_W-1:0] AB_RND = S2_W'(HALF_C);
	localparam logic [L_QW-1:0] CODE_MAX = L_QW'(65535);

	logic signed [S1_W-1:0] fxs, fys, fzs;
	logic signed [S1_W-1:0] lv_s1, av_s1, bv_s1;
	logic signed [S2_W-1:0] nl_s2, na_s2, nb_s2;
	logic                   lneg_s3;
	logic [L_NUM_W-1:0]     ln_s3;
	code_t                  a_s3, b_s3;
	logic [L_QW-1:0]        lq;
	logic                   lneg_d [CDIV_LAT];
	code_t                  a_d    [CDIV_LAT];
	code_t                  b_d    [CDIV_LAT];

	function automatic code_t sat_shift(logic signed [S2_W-1:0] v);
		logic [S2_W-FRAC-1:0] q;
		q = v[S2_W-1:FRAC];
		if (v[S2_W-1]) begin
			return '0;
		end
		if (q > (S2_W - FRAC)'(65535)) begin
			return '1;
		end
		return q[CODE_W-1:0];
	endfunction

	assign fxs = signed'(S1_W'(fx));
	assign fys = signed'(S1_W'(fy));
	assign fzs = signed'(S1_W'(fz));

	always_ff @(posedge clk) begin
		if (en) begin
			lv_s1 <= fys * S1_W'(116) - L_OFS;
			av_s1 <= (fxs - fys) * S1_W'(500) + AB_OFS;
			bv_s1 <= (fys - fzs) * S1_W'(200) + AB_OFS;
			// times 65535 and times 257 as shift and add
			nl_s2 <= (S2_W'(lv_s1) <<< 16) - S2_W'(lv_s1) + L_RND;
			na_s2 <= (S2_W'(av_s1) <<< 8) + S2_W'(av_s1) + AB_RND;
			nb_s2 <= (S2_W'(bv_s1) <<< 8) + S2_W'(bv_s1) + AB_RND;
			lneg_s3 <= nl_s2[S2_W-1];
			ln_s3   <= nl_s2[FRAC+L_NUM_W-1:FRAC];
			a_s3    <= sat_shift(na_s2);
			b_s3    <= sat_shift(nb_s2);
		end
	end

	// divide by 100 after the shift by 2^30
	stcl_cdiv #(
		.NUM_W  (L_NUM_W),
		.QUO_W  (L_QW),
		.Divisor(100)
	) u_ldiv (
		.clk(clk),
		.en (en),
		.num(ln_s3),
		.quo(lq)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			lneg_d[0] <= lneg_s3;
			a_d[0]    <= a_s3;
			b_d[0]    <= b_s3;
			for (int i = 1; i < CDIV_LAT; i++) begin
				lneg_d[i] <= lneg_d[i-1];
				a_d[i]    <= a_d[i-1];
				b_d[i]    <= b_d[i-1];
			end
			if (lneg_d[CDIV_LAT-1]) begin
				lightness_code <= '0;
			end else if (lq > CODE_MAX) begin
				lightness_code <= '1;
			end else begin
				lightness_code <= lq[CODE_W-1:0];
			end
			a_code <= a_d[CDIV_LAT-1];
			b_code <= b_d[CDIV_LAT-1];
		end
	end

endmodule

`default_nettype wire

@@ rtl/core/srgb_to_scaled_cielab.sv @@
`default_nettype none

// sRGB to CIE L*a*b* (D65) converter with 16-bit scaled codes. One pixel
// transfer is taken every clock unless lab_stall holds back a waiting result,
// and one Lab transfer comes out per pixel, in order. Three lanes (red, green,
// blue) linearise through a constant lookup table and feed the D65 matrix;
// three lanes (x, y, z) then run f(t) in parallel, each a 62-stage cube-root
// search (one root bit per two stages) beside a linear segment; final
// stages merge the three f values into L*, a* and b* codes. The latency is set
// mostly by the cube-root pipeline; each constant division is a three-stage
// reciprocal multiplication.
// Every code is within one code of the exact result and saturates to
// 0..65535. Holding lab_stall while a result is waiting freezes the whole
// pipeline, and pix_stall follows it.

module srgb_to_scaled_cielab (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            pix_valid,
	output logic            pix_stall,
	input  logic [7:0]      red,
	input  logic [7:0]      green,
	input  logic [7:0]      blue,
	output logic            lab_valid,
	input  logic            lab_stall,
	output stcl_pkg::code_t lightness_code,
	output stcl_pkg::code_t a_code,
	output stcl_pkg::code_t b_code
);
	import stcl_pkg::*;

	localparam lin_tab_t LIN_TAB = lin_table();
	localparam int P_W = LIN_W + 14;

	// pipeline advance
	logic en;
	logic vld_q [PIPE_LAT];

	// linearised components
	lin_t lr_s1, lg_s1, lb_s1;
	// matrix products
	logic [P_W-1:0] xr_s2, xg_s2, xb_s2;
	logic [P_W-1:0] yr_s2, yg_s2, yb_s2;
	logic [P_W-1:0] zr_s2, zg_s2, zb_s2;
	// numerators for the white point quotients
	logic [XYZ_NUM_W-1:0] xn_s3, yn_s3, zn_s3;
	ratio_t xt, yt, zt;
	f_t     fx, fy, fz;

	// the output register holds the last stage; a waiting result freezes all
	assign en        = !(vld_q[PIPE_LAT-1] && lab_stall);
	assign pix_stall = !en;
	assign lab_valid = vld_q[PIPE_LAT-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < PIPE_LAT; i++) begin
				vld_q[i] <= 1'b0;
			end
		end else if (en) begin
			vld_q[0] <= pix_valid;
			for (int i = 1; i < PIPE_LAT; i++) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	// gamma lanes, table lookup
	always_ff @(posedge clk) begin
		if (en) begin
			lr_s1 <= LIN_TAB[red];
			lg_s1 <= LIN_TAB[green];
			lb_s1 <= LIN_TAB[blue];
		end
	end

	// D65 matrix, coefficients in units of 1/10000
	always_ff @(posedge clk) begin
		if (en) begin
			xr_s2 <= P_W'(lr_s1) * P_W'(4124);
			xg_s2 <= P_W'(lg_s1) * P_W'(3576);
			xb_s2 <= P_W'(lb_s1) * P_W'(1805);
			yr_s2 <= P_W'(lr_s1) * P_W'(2126);
			yg_s2 <= P_W'(lg_s1) * P_W'(7152);
			yb_s2 <= P_W'(lb_s1) * P_W'(722);
			zr_s2 <= P_W'(lr_s1) * P_W'(193);
			zg_s2 <= P_W'(lg_s1) * P_W'(1192);
			zb_s2 <= P_W'(lb_s1) * P_W'(9505);
		end
	end

	// sums with the rounding terms of the white point division
	always_ff @(posedge clk) begin
		if (en) begin
			xn_s3 <= (XYZ_NUM_W'(xr_s2) + XYZ_NUM_W'(xg_s2) + XYZ_NUM_W'(xb_s2))
				* XYZ_NUM_W'(10) + XYZ_NUM_W'(47523);
			yn_s3 <= XYZ_NUM_W'(yr_s2) + XYZ_NUM_W'(yg_s2) + XYZ_NUM_W'(yb_s2)
				+ XYZ_NUM_W'(5000);
			zn_s3 <= (XYZ_NUM_W'(zr_s2) + XYZ_NUM_W'(zg_s2) + XYZ_NUM_W'(zb_s2))
				* XYZ_NUM_W'(10) + XYZ_NUM_W'(54441);
		end
	end

	// division by the white point, scaled by ten for x and z
	stcl_cdiv #(.NUM_W(XYZ_NUM_W), .QUO_W(RAT_W), .Divisor(95047)) u_xdiv (
		.clk(clk), .en(en), .num(xn_s3), .quo(xt)
	);
	stcl_cdiv #(.NUM_W(XYZ_NUM_W), .QUO_W(RAT_W), .Divisor(10000)) u_ydiv (
		.clk(clk), .en(en), .num(yn_s3), .quo(yt)
	);
	stcl_cdiv #(.NUM_W(XYZ_NUM_W), .QUO_W(RAT_W), .Divisor(108883)) u_zdiv (
		.clk(clk), .en(en), .num(zn_s3), .quo(zt)
	);

	// f(t) lanes
	stcl_flab u_fx (.clk(clk), .en(en), .t(xt), .f(fx));
	stcl_flab u_fy (.clk(clk), .en(en), .t(yt), .f(fy));
	stcl_flab u_fz (.clk(clk), .en(en), .t(zt), .f(fz));

	// merge into L*, a*, b* codes; its last stage is the output register
	stcl_lab u_lab (
		.clk           (clk),
		.en            (en),
		.fx            (fx),
		.fy            (fy),
		.fz            (fz),
		.lightness_code(lightness_code),
		.a_code        (a_code),
		.b_code        (b_code)
	);

`ifndef SYNTH
	// input stalls exactly when a finished result is held back
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		pix_stall == (lab_valid && lab_stall))
		else $error("pix_stall does not follow the held result");

	// an accepted pixel enters the first stage
	a_enter: assert property (@(posedge clk) disable iff (!arst_n)
		pix_valid && !pix_stall |=> vld_q[0])
		else $error("accepted pixel lost at entry");

	// an advancing pipeline moves the stage before the output into it
	a_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!pix_stall |=> lab_valid == $past(vld_q[PIPE_LAT-2]))
		else $error("output valid out of step with the pipeline");
`endif

endmodule

`default_nettype wire
